@@ rtl/gww_pkg.sv @@
// Shared types and constants for the greedy word wrap block.
`default_nettype none

package gww_pkg;

  localparam int CMD_BITS         = 2;
  localparam int BYTE_COUNT_BITS  = 3;
  localparam int ADVANCE_BITS     = 12;
  localparam int MAX_WIDTH_BITS   = 20;
  localparam int SPACE_WIDTH_BITS = 12;
  localparam int PEND_BITS        = 16;
  localparam int CFG_INDEX_BITS   = 1;
  localparam int CFG_DATA_BITS    = MAX_WIDTH_BITS;
  localparam int FIFO_DEPTH       = 4;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_GLYPH   = 2'd0,
    CMD_SPACE   = 2'd1,
    CMD_NEWLINE = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MAX_WIDTH   = 1'b0,
    CFG_SPACE_WIDTH = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

@@ rtl/gww_core.sv @@
// Line state registers and the per-item wrap step that emits up to two runs.
`default_nettype none

module gww_core #(
  parameter int OFFSET_BITS = 16,
  parameter int WIDTH_BITS  = 24,
  parameter int RUN_W       = 2 * OFFSET_BITS + WIDTH_BITS + 1
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   take,
  input  wire gww_pkg::cmd_t                          item_cmd,
  input  wire logic [gww_pkg::BYTE_COUNT_BITS-1:0]    item_byte_count,
  input  wire logic [gww_pkg::ADVANCE_BITS-1:0]       item_advance,
  input  wire logic [gww_pkg::MAX_WIDTH_BITS-1:0]     max_width,
  input  wire logic [gww_pkg::SPACE_WIDTH_BITS-1:0]   space_width,
  output logic [1:0]                                  push_cnt,
  output logic [RUN_W-1:0]                            run0,
  output logic [RUN_W-1:0]                            run1
);

  localparam int OB     = OFFSET_BITS;
  localparam int WB     = WIDTH_BITS;
  localparam int GAP_W  = gww_pkg::PEND_BITS + gww_pkg::SPACE_WIDTH_BITS;
  localparam int XW     = ((WB > GAP_W) ? WB : GAP_W) + 2;
  localparam logic [XW-1:0] WID_MAX = {{(XW-WB){1'b0}}, {WB{1'b1}}};
  localparam logic [gww_pkg::PEND_BITS-1:0] PEND_MAX = '1;

  typedef struct packed {
    logic [OB-1:0] b;
    logic [OB-1:0] e;
    logic [WB-1:0] w;
    logic          last;
  } run_t;

  function automatic logic [WB-1:0] sat_w(input logic [XW-1:0] v);
    logic [WB-1:0] r;
    r = (v > WID_MAX) ? WID_MAX[WB-1:0] : v[WB-1:0];
    return r;
  endfunction

  function automatic logic [OB-1:0] move_pos(input logic [OB-1:0] p,
                                             input logic [2:0] n);
    logic [OB:0] s;
    s = {1'b0, p} + (OB+1)'(n);
    return s[OB] ? {OB{1'b1}} : s[OB-1:0];
  endfunction

  logic [OB-1:0]                   pos_r, pos_nxt;
  logic [OB-1:0]                   lbeg_r, lbeg_nxt;
  logic [OB-1:0]                   lend_r, lend_nxt;
  logic [WB-1:0]                   lwid_r, lwid_nxt;
  logic                            holds_r, holds_nxt;
  logic [OB-1:0]                   wbeg_r, wbeg_nxt;
  logic [WB-1:0]                   wwid_r, wwid_nxt;
  logic                            tent_r, tent_nxt;
  logic                            inword_r, inword_nxt;
  logic [gww_pkg::PEND_BITS-1:0]   pend_r, pend_nxt;

  logic [GAP_W-1:0]                gap_full;
  logic [WB-1:0]                   gap;
  logic [2:0]                      bc;
  logic                            cw_active;
  logic [WB-1:0]                   cw_lwid;
  logic [OB-1:0]                   cw_lend;
  logic                            cw_holds;
  logic [gww_pkg::PEND_BITS-1:0]   cw_pend;
  logic [WB-1:0]                   nw;
  run_t                            ra;
  run_t                            rb;
  logic [1:0]                      n_runs;

  assign gap_full = GAP_W'(pend_r) * GAP_W'(space_width);
  assign gap      = sat_w(XW'(gap_full));

  always_comb begin
    if (item_byte_count == 3'd0) begin
      bc = 3'd1;
    end else if (item_byte_count > 3'd4) begin
      bc = 3'd4;
    end else begin
      bc = item_byte_count;
    end
  end

  assign cw_active = inword_r && tent_r;
  assign cw_lwid   = cw_active ? sat_w(XW'(lwid_r) + XW'(gap) + XW'(wwid_r)) : lwid_r;
  assign cw_lend   = cw_active ? pos_r : lend_r;
  assign cw_holds  = cw_active ? 1'b1 : holds_r;
  assign cw_pend   = cw_active ? '0 : pend_r;

  always_comb begin
    pos_nxt    = pos_r;
    lbeg_nxt   = lbeg_r;
    lend_nxt   = lend_r;
    lwid_nxt   = lwid_r;
    holds_nxt  = holds_r;
    wbeg_nxt   = wbeg_r;
    wwid_nxt   = wwid_r;
    tent_nxt   = tent_r;
    inword_nxt = inword_r;
    pend_nxt   = pend_r;
    nw         = '0;
    ra         = '0;
    rb         = '0;
    n_runs     = 2'd0;
    if (take) begin
      case (item_cmd)
        gww_pkg::CMD_GLYPH: begin
          if (max_width == '0) begin
            lend_nxt   = cw_lend;
            holds_nxt  = cw_holds;
            pend_nxt   = cw_pend;
            inword_nxt = 1'b0;
            tent_nxt   = 1'b0;
            lwid_nxt   = sat_w(XW'(cw_lwid) + XW'(item_advance));
            pos_nxt    = move_pos(pos_r, bc);
            lend_nxt   = pos_nxt;
          end else begin
            if (!inword_r) begin
              inword_nxt = 1'b1;
              wbeg_nxt   = pos_r;
              wwid_nxt   = '0;
              tent_nxt   = holds_r;
              if (!holds_r) begin
                lwid_nxt = sat_w(XW'(lwid_r) + XW'(gap));
                pend_nxt = '0;
              end
            end
            if (tent_nxt) begin
              nw = sat_w(XW'(wwid_nxt) + XW'(item_advance));
              if (XW'(lwid_nxt) + XW'(gap) + XW'(nw) > XW'(max_width)) begin
                ra       = '{b: lbeg_r, e: lend_r, w: lwid_nxt, last: 1'b0};
                n_runs   = 2'd1;
                lbeg_nxt = wbeg_nxt;
                lend_nxt = pos_r;
                lwid_nxt = wwid_nxt;
                tent_nxt = 1'b0;
                pend_nxt = '0;
                holds_nxt = 1'b0;
              end else begin
                wwid_nxt = nw;
              end
            end
            if (!tent_nxt) begin
              if (pos_r > lbeg_nxt &&
                  XW'(lwid_nxt) + XW'(item_advance) > XW'(max_width)) begin
                if (n_runs == 2'd0) begin
                  ra = '{b: lbeg_nxt, e: pos_r, w: lwid_nxt, last: 1'b0};
                end else begin
                  rb = '{b: lbeg_nxt, e: pos_r, w: lwid_nxt, last: 1'b0};
                end
                n_runs    = n_runs + 2'd1;
                lbeg_nxt  = pos_r;
                lend_nxt  = pos_r;
                lwid_nxt  = '0;
                holds_nxt = 1'b0;
              end
              lwid_nxt  = sat_w(XW'(lwid_nxt) + XW'(item_advance));
              holds_nxt = 1'b1;
            end
            pos_nxt = move_pos(pos_r, bc);
            if (!tent_nxt) begin
              lend_nxt = pos_nxt;
            end
          end
        end
        gww_pkg::CMD_SPACE: begin
          lwid_nxt   = cw_lwid;
          lend_nxt   = cw_lend;
          holds_nxt  = cw_holds;
          pend_nxt   = cw_pend;
          inword_nxt = 1'b0;
          tent_nxt   = 1'b0;
          pos_nxt    = move_pos(pos_r, 3'd1);
          if (max_width == '0) begin
            lwid_nxt = sat_w(XW'(cw_lwid) + XW'(space_width));
            lend_nxt = pos_nxt;
          end else if (cw_pend != PEND_MAX) begin
            pend_nxt = cw_pend + 1'b1;
          end
        end
        gww_pkg::CMD_NEWLINE: begin
          ra         = '{b: lbeg_r, e: cw_lend, w: cw_lwid, last: 1'b0};
          n_runs     = 2'd1;
          inword_nxt = 1'b0;
          tent_nxt   = 1'b0;
          pos_nxt    = move_pos(pos_r, 3'd1);
          lbeg_nxt   = pos_nxt;
          lend_nxt   = pos_nxt;
          lwid_nxt   = '0;
          holds_nxt  = 1'b0;
          pend_nxt   = '0;
        end
        gww_pkg::CMD_END: begin
          ra         = '{b: lbeg_r, e: cw_lend, w: cw_lwid, last: 1'b1};
          n_runs     = 2'd1;
          pos_nxt    = '0;
          lbeg_nxt   = '0;
          lend_nxt   = '0;
          lwid_nxt   = '0;
          holds_nxt  = 1'b0;
          wbeg_nxt   = '0;
          wwid_nxt   = '0;
          tent_nxt   = 1'b0;
          inword_nxt = 1'b0;
          pend_nxt   = '0;
        end
        default: begin
          n_runs = 2'd0;
        end
      endcase
    end
  end

  assign push_cnt = n_runs;
  assign run0     = ra;
  assign run1     = rb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      lbeg_r   <= '0;
      lend_r   <= '0;
      lwid_r   <= '0;
      holds_r  <= 1'b0;
      wbeg_r   <= '0;
      wwid_r   <= '0;
      tent_r   <= 1'b0;
      inword_r <= 1'b0;
      pend_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      lbeg_r   <= lbeg_nxt;
      lend_r   <= lend_nxt;
      lwid_r   <= lwid_nxt;
      holds_r  <= holds_nxt;
      wbeg_r   <= wbeg_nxt;
      wwid_r   <= wwid_nxt;
      tent_r   <= tent_nxt;
      inword_r <= inword_nxt;
      pend_r   <= pend_nxt;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && item_cmd == gww_pkg::CMD_END |=> pos_r == '0 && lwid_r == '0 && pend_r == '0)
    else $error("state not cleared after end of text");

  a_two_runs_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt == 2'd2 |-> take && item_cmd == gww_pkg::CMD_GLYPH)
    else $error("two runs from a non-glyph transaction");

  a_end_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
    lend_r <= pos_r)
    else $error("open line end past byte position");

endmodule

`default_nettype wire

@@ rtl/gww_run_fifo.sv @@
// Small run queue taking up to two runs per cycle and delivering one per cycle while rd_stall is low.
`default_nettype none

module gww_run_fifo #(
  parameter int RUN_W = 57
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [1:0]       push_cnt,
  input  wire logic [RUN_W-1:0] push_d0,
  input  wire logic [RUN_W-1:0] push_d1,
  output logic                  space_ok,
  output logic                  rd_valid,
  output logic [RUN_W-1:0]      rd_data,
  input  wire logic             rd_stall
);

  localparam int DEPTH = gww_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = PW + 1;

  logic [RUN_W-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             pop;
  logic [PW-1:0]    wr_ptr_p1;

  assign pop       = (count_r != '0) && !rd_stall;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign space_ok  = count_r <= CW'(DEPTH - 2);
  assign rd_valid  = count_r != '0;
  assign rd_data   = mem[rd_ptr_r];

  assign wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + PW'(pop);
  assign count_nxt  = count_r + CW'(push_cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt != 2'd0 |-> count_r + CW'(push_cnt) <= CW'(DEPTH))
    else $error("run queue overflow");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    push_cnt == 2'd0 && pop |=> count_r == $past(count_r) - 1'b1)
    else $error("run queue count lost a pop");

endmodule

`default_nettype wire

@@ rtl/greedy_word_wrap_top.sv @@
// Top level of the greedy word wrap block: input register, config registers, core and run queue.
//
// Input channel (in_*): one code point per transaction, tagged glyph, space,
// newline or end of text, with its byte count and advance. Result channel
// (out_*): one line run per transaction, byte begin, byte end, width and a
// last flag on the final run of the text. Config channel (cfg_*): write
// max_width (index 0) or space_width (index 1); cfg_ready is always high.
// Write config only while no transaction is in flight.
// A code point passes from the input register through the wrap step into the run
// queue, and a run is on out_* once the queue holds it. Throughput: one code
// point per cycle while in_stall is low; the wrap step is combinational logic
// between the input register and the run queue.
// A glyph that both breaks a line and splits an overlong word queues two
// runs in one cycle; the four-entry queue then drains one run per cycle while out_stall is low.
// Reset clears the line state, the queue and both config registers.
// When out_stall holds, the queue fills and in_stall rises once fewer than
// two entries remain free; nothing is dropped.
`default_nettype none

module greedy_word_wrap_top #(
  parameter int OFFSET_BITS = 16,
  parameter int WIDTH_BITS  = 24
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [gww_pkg::CMD_BITS-1:0]          in_cmd,
  input  wire logic [gww_pkg::BYTE_COUNT_BITS-1:0]   in_byte_count,
  input  wire logic [gww_pkg::ADVANCE_BITS-1:0]      in_advance,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [OFFSET_BITS-1:0]                     out_run_begin,
  output logic [OFFSET_BITS-1:0]                     out_run_end,
  output logic [WIDTH_BITS-1:0]                      out_run_width,
  output logic                                       out_run_last,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [gww_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [gww_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int RUN_W = 2 * OFFSET_BITS + WIDTH_BITS + 1;

  logic                                   item_vld_r;
  gww_pkg::cmd_t                          item_cmd_r;
  logic [gww_pkg::BYTE_COUNT_BITS-1:0]    item_bc_r;
  logic [gww_pkg::ADVANCE_BITS-1:0]       item_adv_r;
  logic [gww_pkg::MAX_WIDTH_BITS-1:0]     max_width_r;
  logic [gww_pkg::SPACE_WIDTH_BITS-1:0]   space_width_r;
  logic                                   space_ok;
  logic                                   take;
  logic [1:0]                             push_cnt;
  logic [RUN_W-1:0]                       run0;
  logic [RUN_W-1:0]                       run1;
  logic [RUN_W-1:0]                       rd_data;

  assign take      = item_vld_r && space_ok;
  assign in_stall  = item_vld_r && !space_ok;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_cmd_r <= gww_pkg::cmd_t'(in_cmd);
      item_bc_r  <= in_byte_count;
      item_adv_r <= in_advance;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_width_r   <= '0;
      space_width_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (gww_pkg::cfg_idx_t'(cfg_index))
        gww_pkg::CFG_MAX_WIDTH: begin
          max_width_r <= cfg_data;
        end
        gww_pkg::CFG_SPACE_WIDTH: begin
          space_width_r <= cfg_data[gww_pkg::SPACE_WIDTH_BITS-1:0];
        end
        default: begin
          max_width_r <= max_width_r;
        end
      endcase
    end
  end

  gww_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .WIDTH_BITS  (WIDTH_BITS),
    .RUN_W       (RUN_W)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take),
    .item_cmd        (item_cmd_r),
    .item_byte_count (item_bc_r),
    .item_advance    (item_adv_r),
    .max_width       (max_width_r),
    .space_width     (space_width_r),
    .push_cnt        (push_cnt),
    .run0            (run0),
    .run1            (run1)
  );

  gww_run_fifo #(
    .RUN_W (RUN_W)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .push_d0  (run0),
    .push_d1  (run1),
    .space_ok (space_ok),
    .rd_valid (out_valid),
    .rd_data  (rd_data),
    .rd_stall (out_stall)
  );

  assign out_run_begin = rd_data[RUN_W-1 -: OFFSET_BITS];
  assign out_run_end   = rd_data[RUN_W-1-OFFSET_BITS -: OFFSET_BITS];
  assign out_run_width = rd_data[WIDTH_BITS:1];
  assign out_run_last  = rd_data[0];

endmodule

`default_nettype wire
